// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LCT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Types and codes shared by the LRU cache controller and datapath.
// ----------------------------------------------------------------------------
package lct_pkg;

   // Request action codes.
   typedef enum logic [2:0] {
      ACT_GET   = 3'd0,
      ACT_PUT   = 3'd1,
      ACT_EVICT = 3'd2,
      ACT_CLEAR = 3'd3,
      ACT_SWEEP = 3'd4,
      ACT_TICK  = 3'd5
   } action_type;

   // Configuration register indexes.
   localparam logic CSR_CAPACITY    = 1'b0;
   localparam logic CSR_DEFAULT_TTL = 1'b1;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MATCH,
      OP_GET_HIT,
      OP_GET_MISS,
      OP_PUT_REFRESH,
      OP_DROP_LRU,
      OP_INSERT,
      OP_EVICT,
      OP_CLEAR,
      OP_SWEEP_STEP,
      OP_TICK,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       found;
      logic       live;
      logic       full;
      logic       sweep_last;
   } dp_status_type;

endpackage

// ----- hdl/lru_cache_with_ttl_expiry.sv -----
// Sequence: a word is latched on accept, then passes the match, execute and finish
// states; a get hit adds a read state, a put that evicts adds an insert state, and a
// sweep checks one entry per cycle. One word is in flight at a time; the input reopens
// the cycle after the reply is registered, and a new word is taken while that reply waits.
// Reset: synchronous, active high; empties the cache, clears time and counters,
// and restores capacity 16 and default lifetime 300.
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_expiry
// Fully associative key/payload cache with LRU replacement and tick-based expiry.
// ----------------------------------------------------------------------------
module lru_cache_with_ttl_expiry
   import lct_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   // action[2:0], key[66:3], payload[130:67], lifetime[146:131], zero pad
   input  logic [151:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // hit[0], data[64:1], removed[69:65], occupancy[74:70],
   // hits_total[106:75], misses_total[138:107], zero pad
   output logic [143:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wen,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          hit;
   logic [63:0]   data;
   logic [4:0]    removed, occupancy;
   logic [31:0]   hits_total, misses_total;

   lct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lct_dpath #(
      .ENTRIES   (ENTRIES),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_tdata[2:0]),
      .req_key          (req_tdata[66:3]),
      .req_payload      (req_tdata[130:67]),
      .req_lifetime     (req_tdata[146:131]),
      .rsp_hit          (hit),
      .rsp_data         (data),
      .rsp_removed      (removed),
      .rsp_occupancy    (occupancy),
      .rsp_hits_total   (hits_total),
      .rsp_misses_total (misses_total)
   );

   assign rsp_tdata = {5'd0, misses_total, hits_total, occupancy, removed, data, hit};

endmodule

// ----- hdl/lct_ram.sv -----
// ----------------------------------------------------------------------------
// lct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lct_ctrl.sv -----
// ----------------------------------------------------------------------------
// lct_ctrl
// Sequencer that walks each request word through match, execute and reply.
// ----------------------------------------------------------------------------
module lct_ctrl
   import lct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC,
      S_INSERT,
      S_SWEEP,
      S_READ,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // Next state and datapath command.
   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.op   = OP_MATCH;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (status.action)
               ACT_GET: begin
                  if (status.live) begin
                     cmd.op   = OP_GET_HIT;
                     state_in = S_READ;
                  end else begin
                     cmd.op = OP_GET_MISS;
                  end
               end
               ACT_PUT: begin
                  if (status.found) begin
                     cmd.op = OP_PUT_REFRESH;
                  end else if (status.full) begin
                     cmd.op   = OP_DROP_LRU;
                     state_in = S_INSERT;
                  end else begin
                     cmd.op = OP_INSERT;
                  end
               end
               ACT_EVICT: cmd.op = OP_EVICT;
               ACT_CLEAR: cmd.op = OP_CLEAR;
               ACT_SWEEP: state_in = S_SWEEP;
               ACT_TICK:  cmd.op = OP_TICK;
               default:   cmd.op = OP_NONE;
            endcase
         end
         S_INSERT: begin
            cmd.op   = OP_INSERT;
            state_in = S_FINISH;
         end
         S_SWEEP: begin
            cmd.op = OP_SWEEP_STEP;
            if (status.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op        = OP_FINISH;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered reply valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

// ----- hdl/lct_dpath.sv -----
// ----------------------------------------------------------------------------
// lct_dpath
// Entry tags, recency ranks, expiry times, counters and the reply register.
// ----------------------------------------------------------------------------
module lct_dpath
   import lct_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          csr_wen,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic [2:0]    req_action,
   input  logic [63:0]   req_key,
   input  logic [63:0]   req_payload,
   input  logic [15:0]   req_lifetime,
   output logic          rsp_hit,
   output logic [63:0]   rsp_data,
   output logic [4:0]    rsp_removed,
   output logic [4:0]    rsp_occupancy,
   output logic [31:0]   rsp_hits_total,
   output logic [31:0]   rsp_misses_total
);

   localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int TW1 = TIME_BITS + 1;

   // Latched request word.
   logic [2:0]  act_ff;
   logic [63:0] key_ff;
   logic [63:0] pay_ff;
   logic [15:0] life_ff;

   // Configuration.
   logic [4:0]  cap_ff;
   logic [15:0] ttl_ff;

   // Entry state.
   logic [ENTRIES-1:0]   valid_ff;
   logic [63:0]          tag_ff  [ENTRIES];
   logic [TIME_BITS-1:0] exp_ff  [ENTRIES];
   logic [IW-1:0]        rank_ff [ENTRIES];
   logic [TIME_BITS-1:0] time_ff;
   logic [31:0]          hits_ff;
   logic [31:0]          miss_ff;
   logic [CW-1:0]        count_ff;

   // Per-item scratch.
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] expd_ff;
   logic [IW-1:0]      sweep_ff;
   logic [CW-1:0]      removed_ff;
   logic               hit_ff;

   // Reply register.
   logic        out_hit_ff;
   logic [63:0] out_data_ff;
   logic [4:0]  out_removed_ff;
   logic [4:0]  out_occ_ff;
   logic [31:0] out_hits_ff;
   logic [31:0] out_miss_ff;

   logic [IW-1:0]        match_idx, lru_idx, free_idx, drop_idx;
   logic [ENTRIES-1:0]   lru_vec;
   logic                 free_any, found, live, full, do_drop, do_recent, do_insert;
   logic [31:0]          cap_eff;
   logic [15:0]          ttl_sel;
   logic [TW1-1:0]       exp_sum;
   logic [TIME_BITS-1:0] exp_new;
   logic                 ram_wen, ram_ren;
   logic [IW-1:0]        ram_waddr;
   logic [63:0]          ram_rdata;

   // Index encoders over the match, least-recent and free vectors.
   always_comb begin
      match_idx = '0;
      lru_idx   = '0;
      free_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lru_vec[i] = valid_ff[i] && (rank_ff[i] == IW'(count_ff - 1'b1));
         if (match_ff[i]) match_idx = match_idx | IW'(i);
         if (lru_vec[i])  lru_idx   = lru_idx | IW'(i);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IW'(i);
      end
   end

   assign free_any = ~&valid_ff;
   assign found    = |match_ff;
   assign live     = |(match_ff & ~expd_ff);

   // Effective capacity, clamped to one through the entry count.
   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = 32'd1;
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = 32'(ENTRIES);
      end else begin
         cap_eff = 32'(cap_ff);
      end
   end
   assign full = 32'(count_ff) >= cap_eff;

   // Saturating expiry time for put.
   assign ttl_sel = (life_ff != 16'd0) ? life_ff : ttl_ff;
   assign exp_sum = {1'b0, time_ff} + TW1'(ttl_sel);
   assign exp_new = exp_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : exp_sum[TIME_BITS-1:0];

   // Which entry leaves, and whether it does.
   always_comb begin
      drop_idx = match_idx;
      do_drop  = 1'b0;
      case (cmd.op)
         OP_GET_MISS, OP_EVICT: do_drop = found;
         OP_DROP_LRU: begin
            drop_idx = lru_idx;
            do_drop  = |lru_vec;
         end
         OP_SWEEP_STEP: begin
            drop_idx = sweep_ff;
            do_drop  = valid_ff[sweep_ff] && expd_ff[sweep_ff];
         end
         default: do_drop = 1'b0;
      endcase
   end

   assign do_recent = (cmd.op == OP_GET_HIT) || (cmd.op == OP_PUT_REFRESH);
   assign do_insert = (cmd.op == OP_INSERT) && free_any;

   // Payload store.
   assign ram_wen   = (cmd.op == OP_PUT_REFRESH) || do_insert;
   assign ram_waddr = (cmd.op == OP_INSERT) ? free_idx : match_idx;
   assign ram_ren   = (cmd.op == OP_GET_HIT);

   lct_ram #(
      .WIDTH (64),
      .DEPTH (ENTRIES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (pay_ff),
      .rd_en   (ram_ren),
      .rd_addr (match_idx),
      .rd_data (ram_rdata)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 5'd16;
         ttl_ff <= 16'd300;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CAPACITY:    cap_ff <= csr_wdata[4:0];
            CSR_DEFAULT_TTL: ttl_ff <= csr_wdata;
            default:         cap_ff <= cap_ff;
         endcase
      end
   end

   // Request latch, match vectors and reply register.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         act_ff  <= req_action;
         key_ff  <= req_key;
         pay_ff  <= req_payload;
         life_ff <= req_lifetime;
      end
      if (cmd.op == OP_MATCH) begin
         for (int i = 0; i < ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (tag_ff[i] == key_ff);
            expd_ff[i]  <= exp_ff[i] <= time_ff;
         end
      end
      if (cmd.op == OP_FINISH) begin
         out_hit_ff     <= hit_ff;
         out_data_ff    <= hit_ff ? ram_rdata : 64'd0;
         out_removed_ff <= 5'(removed_ff);
         out_occ_ff     <= 5'(count_ff);
         out_hits_ff    <= hits_ff;
         out_miss_ff    <= miss_ff;
      end
   end

   // Tag and expiry writes on insert and refresh.
   always_ff @(posedge clock) begin
      if (do_insert) begin
         tag_ff[free_idx] <= key_ff;
         exp_ff[free_idx] <= exp_new;
      end else if (cmd.op == OP_PUT_REFRESH) begin
         exp_ff[match_idx] <= exp_new;
      end
   end

   // Valid bits, ranks, count, time and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         count_ff   <= '0;
         time_ff    <= '0;
         hits_ff    <= '0;
         miss_ff    <= '0;
         sweep_ff   <= '0;
         removed_ff <= '0;
         hit_ff     <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               hit_ff     <= 1'b0;
               removed_ff <= '0;
            end
            OP_MATCH: sweep_ff <= '0;
            OP_GET_HIT: begin
               hit_ff <= 1'b1;
               if (hits_ff != 32'hFFFF_FFFF) hits_ff <= hits_ff + 32'd1;
            end
            OP_GET_MISS: begin
               if (miss_ff != 32'hFFFF_FFFF) miss_ff <= miss_ff + 32'd1;
            end
            OP_CLEAR: begin
               valid_ff <= '0;
               count_ff <= '0;
               hits_ff  <= '0;
               miss_ff  <= '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_ff[i] <= '0;
               end
            end
            OP_SWEEP_STEP: sweep_ff <= sweep_ff + 1'b1;
            OP_TICK: begin
               if (time_ff != {TIME_BITS{1'b1}}) time_ff <= time_ff + 1'b1;
            end
            default: hit_ff <= hit_ff;
         endcase

         // Removal closes the gap in the rank order.
         if (do_drop) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] > rank_ff[drop_idx]) begin
                  rank_ff[i] <= rank_ff[i] - 1'b1;
               end
            end
            rank_ff[drop_idx]  <= '0;
            valid_ff[drop_idx] <= 1'b0;
            if (count_ff != '0) count_ff <= count_ff - 1'b1;
            if (cmd.op == OP_SWEEP_STEP) removed_ff <= removed_ff + 1'b1;
         end

         // A use moves the entry to the front.
         if (do_recent) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] < rank_ff[match_idx]) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
            rank_ff[match_idx] <= '0;
         end

         // A new entry enters at the front of the order.
         if (do_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + 1'b1;
            end
            rank_ff[free_idx]  <= '0;
            valid_ff[free_idx] <= 1'b1;
            count_ff           <= count_ff + 1'b1;
         end
      end
   end

   assign status.action     = act_ff;
   assign status.found      = found;
   assign status.live       = live;
   assign status.full       = full;
   assign status.sweep_last = (sweep_ff == IW'(ENTRIES - 1));

   assign rsp_hit          = out_hit_ff;
   assign rsp_data         = out_data_ff;
   assign rsp_removed      = out_removed_ff;
   assign rsp_occupancy    = out_occ_ff;
   assign rsp_hits_total   = out_hits_ff;
   assign rsp_misses_total = out_miss_ff;

endmodule

// ----- hdl/lct_checker.sv -----
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks on the cache reply stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lct_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [143:0] rsp_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // A stalled reply stays offered.
   `LCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "reply dropped while stalled")

   // A miss returns zero data.
   `LCT_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[64:1] == 64'd0, "data nonzero without hit")

   // A hit never comes from a sweep.
   `LCT_ASSERT_IMPL(a_hit_no_sweep, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[69:65] == 5'd0, "hit with removed count")

   // One word in flight: the input closes after an accept.
   `LCT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while busy")

endmodule

bind lru_cache_with_ttl_expiry lct_checker u_lct_checker (.*);
